// ===== sv/pes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_pkg
// shared constants for the product-except-self block
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int unsigned MAX_LEN_DEF    = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned POS_W          = 6;
  localparam int unsigned MUL_CHUNK      = 32;

endpackage

// ===== sv/pes_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_in_if / pes_out_if
// valid/ready channels for element beats and result beats
// ----------------------------------------------------------------------------
interface pes_in_if import pes_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink (input valid, input value, input last_item, output ready);
endinterface

interface pes_out_if import pes_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] product;
  logic [POS_W-1:0]          position;
  logic                      truncated;
  logic                      last_result;

  modport source (output valid, output product, output position, output truncated,
                  output last_result, input ready);
  modport sink (input valid, input product, input position, input truncated,
                input last_result, output ready);
endinterface

// ===== sv/pes_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_mul
// shared wrapping multiplier, one 32x32 partial product per cycle
// ----------------------------------------------------------------------------
module pes_mul import pes_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] res_o
);

  localparam int unsigned STEPS     = (DATA_WIDTH > MUL_CHUNK) ? 3 : 1;
  localparam logic [1:0]  LAST_STEP = 2'(STEPS - 1);

  logic                  busy_q;
  logic [1:0]            step_q;
  logic [DATA_WIDTH-1:0] a_q, b_q, acc_q, acc_d;
  logic [63:0]           a_w, b_w, prod, addend, base, sum;
  logic [31:0]           x, y;

  assign a_w = 64'(a_q);
  assign b_w = 64'(b_q);

  always_comb begin
    case (step_q)
      2'd0: begin
        x = a_w[31:0];
        y = b_w[31:0];
      end
      2'd1: begin
        x = a_w[31:0];
        y = b_w[63:32];
      end
      default: begin
        x = a_w[63:32];
        y = b_w[31:0];
      end
    endcase
  end

  assign prod   = 64'(x) * 64'(y);
  assign addend = (step_q == 2'd0) ? prod : {prod[31:0], 32'd0};
  assign base   = (step_q == 2'd0) ? 64'd0 : 64'(acc_q);
  assign sum    = base + addend;
  assign acc_d  = sum[DATA_WIDTH-1:0];

  assign done_o = busy_q && (step_q == LAST_STEP);
  assign res_o  = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 2'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= 2'd0;
    end else if (busy_q) begin
      if (step_q == LAST_STEP) begin
        busy_q <= 1'b0;
      end
      step_q <= step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (busy_q) begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== sv/pes_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_store
// element and prefix store, one write and one registered read port
// ----------------------------------------------------------------------------
module pes_store import pes_pkg::*; #(
  parameter int unsigned MAX_LEN    = MAX_LEN_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned IDX_W     = $clog2(MAX_LEN)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [IDX_W-1:0]        waddr_i,
  input  logic [2*DATA_WIDTH-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [IDX_W-1:0]        raddr_i,
  output logic [2*DATA_WIDTH-1:0] rdata_o
);

  logic [2*DATA_WIDTH-1:0] mem_q [MAX_LEN];
  logic [2*DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/product_except_self.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// product_except_self
// product of all other elements, by stored prefixes and a running suffix
//
//   channel  dir  beat
//   in_i     in   value, last_item
//   out_o    out  product, position, truncated, last_result
//
// a loaded element is accepted in S_IDLE and its prefix multiply ends in S_PFX
// (one shared multiplier, one or three partial products per multiply)
// after the last element each result steps through S_RD, S_PM, S_PW, S_OUT
// and S_SW: two multiplies and one store read per index, plus output stalls
// results leave from an output register, so a pending result does not
// block the next element; no clearing pass after reset
// ----------------------------------------------------------------------------
module product_except_self import pes_pkg::*; #(
  parameter int unsigned MAX_LEN    = MAX_LEN_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pes_in_if.sink    in_i,
  pes_out_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W = $clog2(MAX_LEN);
  localparam int unsigned DW    = DATA_WIDTH;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PFX  = 7'b0000010,
    S_RD   = 7'b0000100,
    S_PM   = 7'b0001000,
    S_PW   = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_SW   = 7'b1000000
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DW-1:0]     prefix_q, suffix_q, prod_q;
  logic              ovf_q, last_q;

  logic              out_valid_q, out_trunc_q, out_last_q;
  logic [VALUE_W-1:0] out_prod_q;
  logic [POS_W-1:0]  out_pos_q;

  logic              accept, full, slot_free;
  logic [DW-1:0]     v_ext;
  logic              mul_start, mul_done;
  logic [DW-1:0]     mul_a, mul_b, mul_res;
  logic              we, re;
  logic [2*DW-1:0]   rdata;
  logic [CNT_W-1:0]  count_inc;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (count_q == CNT_W'(MAX_LEN));
  assign v_ext      = DW'(in_i.value);
  assign slot_free  = !out_valid_q || out_o.ready;
  assign count_inc  = count_q + CNT_W'(1);
  assign we         = accept && !full;
  assign re         = (state_q == S_RD);

  always_comb begin
    case (state_q)
      S_IDLE: begin
        mul_start = accept && !full;
        mul_a     = prefix_q;
        mul_b     = v_ext;
      end
      S_PM: begin
        mul_start = 1'b1;
        mul_a     = rdata[DW-1:0];
        mul_b     = suffix_q;
      end
      S_OUT: begin
        mul_start = slot_free;
        mul_a     = suffix_q;
        mul_b     = rdata[2*DW-1:DW];
      end
      default: begin
        mul_start = 1'b0;
        mul_a     = prefix_q;
        mul_b     = suffix_q;
      end
    endcase
  end

  pes_mul #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  pes_store #(
    .MAX_LEN    (MAX_LEN),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i ({v_ext, prefix_q}),
    .re_i    (re),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      prefix_q <= DW'(1);
      suffix_q <= DW'(1);
      ovf_q    <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            last_q <= in_i.last_item;
            if (full) begin
              ovf_q <= 1'b1;
              if (in_i.last_item) begin
                idx_q    <= IDX_W'(MAX_LEN - 1);
                suffix_q <= DW'(1);
                state_q  <= S_RD;
              end
            end else begin
              count_q <= count_inc;
              state_q <= S_PFX;
            end
          end
        end
        S_PFX: begin
          if (mul_done) begin
            prefix_q <= mul_res;
            if (last_q) begin
              idx_q    <= IDX_W'(count_q - CNT_W'(1));
              suffix_q <= DW'(1);
              state_q  <= S_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_RD: begin
          state_q <= S_PM;
        end
        S_PM: begin
          state_q <= S_PW;
        end
        S_PW: begin
          if (mul_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            state_q <= S_SW;
          end
        end
        S_SW: begin
          if (mul_done) begin
            suffix_q <= mul_res;
            if (idx_q == '0) begin
              count_q  <= '0;
              prefix_q <= DW'(1);
              ovf_q    <= 1'b0;
              state_q  <= S_IDLE;
            end else begin
              idx_q   <= idx_q - IDX_W'(1);
              state_q <= S_RD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PW && mul_done) begin
      prod_q <= mul_res;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && slot_free) begin
      out_prod_q  <= VALUE_W'(prod_q);
      out_pos_q   <= POS_W'(idx_q);
      out_trunc_q <= ovf_q;
      out_last_q  <= (idx_q == '0);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.product     = out_prod_q;
  assign out_o.position    = out_pos_q;
  assign out_o.truncated   = out_trunc_q;
  assign out_o.last_result = out_last_q;

endmodule

// ===== dv/tb_product_except_self.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_product_except_self
// self-checking bench for the product-except-self block: element beats go in
// over the input channel, each beat is folded into a local prefix/suffix
// predictor and the result beats on the output channel are compared in order
// against the queued products, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module tb_product_except_self;
  import pes_pkg::*;

  localparam int unsigned DEPTH       = MAX_LEN_DEF;
  localparam int unsigned GAP_MAX     = 12;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned ITEM_TARGET = 350;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [VALUE_W-1:0] product;
    logic [POS_W-1:0]   position;
    logic               truncated;
    logic               last_result;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pes_in_if  in_ch ();
  pes_out_if out_ch ();

  product_except_self uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // predictor state
  logic [VALUE_W-1:0] elem_mem   [DEPTH];
  logic [VALUE_W-1:0] prefix_mem [DEPTH];
  logic [VALUE_W-1:0] prefix_acc = 1;
  int unsigned        elem_cnt   = 0;
  bit                 dropped    = 1'b0;

  result_t     products_due [$];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned sent_items = 0;
  bit          no_idle    = 1'b0;

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    if (no_idle || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [VALUE_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      2, 3, 4: return VALUE_W'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  // fold one accepted element into the prefix store; on the last one walk back
  task automatic fold_element(logic [VALUE_W-1:0] v, logic last);
    logic [VALUE_W-1:0] suffix;
    int                 idx;
    result_t            r;
    if (elem_cnt < DEPTH) begin
      elem_mem[elem_cnt]   = v;
      prefix_mem[elem_cnt] = prefix_acc;
      prefix_acc           = prefix_acc * v;
      elem_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      suffix = 1;
      for (idx = int'(elem_cnt) - 1; idx >= 0; idx--) begin
        r.product     = prefix_mem[idx] * suffix;
        r.position    = POS_W'(idx);
        r.truncated   = dropped;
        r.last_result = (idx == 0);
        products_due.push_back(r);
        suffix = suffix * elem_mem[idx];
      end
      prefix_acc = 1;
      elem_cnt   = 0;
      dropped    = 1'b0;
    end
  endtask

  task automatic push_element(logic [VALUE_W-1:0] v, logic last);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= v;
    in_ch.last_item <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    fold_element(v, last);
    sent_items++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (products_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_single_element();
    push_element(32'h8000_0000, 1'b1);
    push_element(32'h0000_0005, 1'b1);
  endtask

  task automatic test_extremes_and_zeros();
    push_element(32'h7fff_ffff, 1'b0);
    push_element(32'h8000_0000, 1'b0);
    push_element(32'hffff_ffff, 1'b0);
    push_element(32'h0000_0001, 1'b1);
    // two zeros: every product is zero
    push_element(32'h0000_0000, 1'b0);
    push_element(32'h0000_0003, 1'b0);
    push_element(32'h0000_0000, 1'b1);
    // one zero: only its own slot is non-zero
    push_element(32'h0000_0000, 1'b0);
    push_element(32'hffff_fff9, 1'b0);
    push_element(32'h0000_0009, 1'b1);
    push_element(32'hffff_ffff, 1'b0);
    push_element(32'hffff_ffff, 1'b0);
    push_element(32'h0000_0002, 1'b1);
  endtask

  task automatic test_full_store();
    int unsigned k;
    no_idle = 1'b1;
    for (k = 0; k < DEPTH; k++) begin
      if (k == DEPTH / 2) begin
        no_idle = 1'b0;
      end
      push_element(draw_value(), k == DEPTH - 1);
    end
  endtask

  // two surplus beats and a surplus last beat, all dropped, then a two-element array
  task automatic test_store_overflow();
    int unsigned k;
    for (k = 0; k < DEPTH + 3; k++) begin
      push_element(draw_value(), k == DEPTH + 2);
    end
    push_element(draw_value(), 1'b0);
    push_element(draw_value(), 1'b1);
  endtask

  task automatic test_random_arrays();
    int unsigned len;
    int unsigned k;
    bit          paused;
    paused = 1'b0;
    while (sent_items < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        7, 8:    len = $urandom_range(9, 32);
        9:       len = $urandom_range(33, DEPTH);
        default: len = $urandom_range(1, 8);
      endcase
      no_idle = ($urandom_range(0, 4) == 0);
      for (k = 0; k < len; k++) begin
        push_element(draw_value(), k == len - 1);
      end
      if (!paused && sent_items > ITEM_TARGET - 100) begin
        paused = 1'b1;
        wait_drained();
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_checker
    result_t     seen;
    result_t     want;
    int unsigned stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      seen = '{out_ch.product, out_ch.position, out_ch.truncated, out_ch.last_result};
      if (products_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected result beat: product %h position %0d trunc %b last %b",
                   seen.product, seen.position, seen.truncated, seen.last_result);
        end
      end else begin
        want = products_due.pop_front();
        if (seen.product !== want.product || seen.position !== want.position ||
            seen.truncated !== want.truncated || seen.last_result !== want.last_result) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch at %0t: product %h/%h position %0d/%0d trunc %b/%b last %b/%b",
                     $realtime, want.product, seen.product, want.position, seen.position,
                     want.truncated, seen.truncated, want.last_result, seen.last_result);
          end
        end
      end
    end
  end

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.value     <= '0;
    in_ch.last_item <= 1'b0;
    rst_ni          <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_element();
    test_extremes_and_zeros();
    wait_drained();
    test_full_store();
    test_store_overflow();
    test_random_arrays();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && products_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pes_pkg.sv
sv/pes_if.sv
sv/pes_mul.sv
sv/pes_store.sv
sv/product_except_self.sv
dv/tb_product_except_self.sv
